// ===== sv/ctli_pkg.sv =====
// Shared types, constants and helpers of the curve table interpolation core.
// Used by ctli_muldiv and curve_table_linear_interp_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctli_pkg;

  // Table geometry.
  localparam int TableDepth = 256;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  // Datapath widths.
  localparam int DataW   = 32;
  localparam int MagW    = 33;
  localparam int ProdW   = 2 * MagW;
  localparam int StepW   = $clog2(ProdW);
  localparam int MulSteps = MagW;
  localparam int DivSteps = ProdW;

  // Item kinds.
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncEval  = 1'b1;

  // Result status codes.
  localparam logic [2:0] StInterp = 3'd0;
  localparam logic [2:0] StBelow  = 3'd1;
  localparam logic [2:0] StAbove  = 3'd2;
  localparam logic [2:0] StEmpty  = 3'd3;
  localparam logic [2:0] StWrite  = 3'd4;
  localparam logic [2:0] StFault  = 3'd5;

  // Request to the shared multiply/divide unit.
  typedef struct packed {
    logic            start;
    logic [MagW-1:0] ady;
    logic [MagW-1:0] adx;
    logic [MagW-1:0] den;
  } md_req_t;

  // Response of the shared multiply/divide unit.
  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] quot;
  } md_rsp_t;

  // Arithmetic shift right by one, which rounds toward negative infinity.
  function automatic logic [DataW-1:0] half_floor(input logic [DataW-1:0] v);
    half_floor = {v[DataW-1], v[DataW-1:1]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/ctli_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the packed (x, y) sample table.
`timescale 1ns / 1ps
`default_nettype none

module ctli_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/ctli_muldiv.sv =====
// Serial unsigned multiply followed by serial restoring divide, sharing one adder.
// Computes (ady * adx) / den one bit per cycle; depends on ctli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctli_muldiv (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctli_pkg::md_req_t req_i,
  output ctli_pkg::md_rsp_t      rsp_o
);

  import ctli_pkg::*;

  localparam logic [1:0] MdIdle = 2'd0;
  localparam logic [1:0] MdMul  = 2'd1;
  localparam logic [1:0] MdDiv  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [ProdW-1:0] p_q, p_d;
  logic [MagW-1:0]  a_q, a_d;
  logic [MagW-1:0]  den_q, den_d;
  logic [MagW-1:0]  rem_q, rem_d;

  // Shared adder: add for multiply steps, subtract for divide steps.
  logic [MagW:0]   op_a, op_b;
  logic            op_sub;
  logic [MagW+1:0] sum;
  logic [MagW:0]   trial;

  assign trial = {rem_q, p_q[ProdW-1]};

  always_comb begin
    if (state_q == MdDiv) begin
      op_a   = trial;
      op_b   = {1'b0, den_q};
      op_sub = 1'b1;
    end else begin
      op_a   = {1'b0, p_q[ProdW-1:MagW]};
      op_b   = p_q[0] ? {1'b0, a_q} : '0;
      op_sub = 1'b0;
    end
  end

  assign sum = {1'b0, op_a} + (op_sub ? {1'b1, ~op_b} : {1'b0, op_b})
             + {{(MagW+1){1'b0}}, op_sub};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    p_d     = p_q;
    a_d     = a_q;
    den_d   = den_q;
    rem_d   = rem_q;
    unique case (state_q)
      MdIdle: begin
        if (req_i.start) begin
          a_d     = req_i.ady;
          den_d   = req_i.den;
          p_d     = {{MagW{1'b0}}, req_i.adx};
          rem_d   = '0;
          cnt_d   = '0;
          state_d = MdMul;
        end
      end
      MdMul: begin
        p_d   = {sum[MagW:0], p_q[MagW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(MulSteps - 1)) begin
          cnt_d   = '0;
          state_d = MdDiv;
        end
      end
      MdDiv: begin
        // A clear borrow bit means the trial remainder reached the divisor.
        if (!sum[MagW+1]) begin
          rem_d = sum[MagW-1:0];
        end else begin
          rem_d = trial[MagW-1:0];
        end
        p_d   = {p_q[ProdW-2:0], ~sum[MagW+1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(DivSteps - 1)) begin
          done_d  = 1'b1;
          state_d = MdIdle;
        end
      end
      default: state_d = MdIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MdIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    a_q   <= a_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = p_q;

endmodule

`default_nettype wire

// ===== sv/curve_table_linear_interp_core.sv =====
// Top level of the piecewise-linear curve table: sequencer, search and result stage.
// Depends on ctli_pkg, ctli_ram and ctli_muldiv.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Items arrive on the s_axis channel. tuser carries the kind: a write item stores
// (abscissa, ordinate) at entry_index; an evaluate item looks up abscissa in the
// table. Every item gives exactly one result transfer on the m_axis channel, with
// the value in tdata and the status code in tuser.
// The cfg channel sets sample_count, the number of entries in use; it is always
// ready and should only be written while no item is in flight.
// A write item goes straight to the result stage. An evaluate item scans the table with
// one RAM read per cycle until it finds an entry above the query or every entry is at
// or below it. An interpolated result then passes through the serial multiply/divide
// unit. s_axis_tready is low while an item is busy. The result sits in an output
// register; the core accepts the next item while it waits, and holds a finished
// result internally until the receiver takes the previous one. Reset clears the
// count to zero and drops any pending transfer; the table contents are undefined
// until written.

module curve_table_linear_interp_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: sample_count.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [8:0]  cfg_data_i,
  // Input items.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [71:0] s_axis_tdata_i,  // entry_index[7:0], abscissa[39:8], ordinate[71:40]
  input  wire logic [0:0]  s_axis_tuser_i,  // func[0]
  // Results.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // curve_value[31:0]
  output logic [2:0]       m_axis_tuser_o   // status[2:0]
);

  import ctli_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SSrch  = 3'd1;
  localparam logic [2:0] SPrep  = 3'd2;
  localparam logic [2:0] SArith = 3'd3;
  localparam logic [2:0] SRes   = 3'd4;
  localparam logic [2:0] SFin   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [8:0]       count_q;
  logic [CntW-1:0]  n_q, n_d;
  logic [CntW-1:0]  s_q, s_d;
  logic [DataW-1:0] query_q, query_d;
  logic [DataW-1:0] x_prev_q, x_prev_d;
  logic [DataW-1:0] y_prev_q, y_prev_d;
  logic [MagW-1:0]  dy_q, dy_d;
  logic [MagW-1:0]  dx_q, dx_d;
  logic [MagW-1:0]  den_q, den_d;
  logic             neg_q, neg_d;
  logic [MagW:0]    mag_q, mag_d;
  logic [DataW-1:0] res_val_q, res_val_d;
  logic [2:0]       res_st_q, res_st_d;
  logic             m_valid_q, m_valid_d;
  logic [DataW-1:0] m_data_q, m_data_d;
  logic [2:0]       m_user_q, m_user_d;

  logic             in_func;
  logic [7:0]       in_index;
  logic [DataW-1:0] in_abscissa;
  logic [DataW-1:0] in_ordinate;
  logic             in_xfer;

  assign in_func     = s_axis_tuser_i[0];
  assign in_index    = s_axis_tdata_i[7:0];
  assign in_abscissa = s_axis_tdata_i[39:8];
  assign in_ordinate = s_axis_tdata_i[71:40];

  assign s_axis_tready_o = (state_q == SIdle);
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Sample table: x in the low word, y in the high word.
  logic              ram_we;
  logic [AddrW-1:0]  ram_raddr;
  logic [2*DataW-1:0] ram_rdata;
  logic [DataW-1:0]  x_cur, y_cur;
  logic              index_ok;

  assign index_ok = ({24'd0, in_index} < 32'(TableDepth));
  assign ram_we   = in_xfer & (in_func == FuncWrite) & index_ok;
  assign ram_raddr = (state_q == SSrch) ? AddrW'(s_q + 1'b1) : '0;
  assign x_cur = ram_rdata[DataW-1:0];
  assign y_cur = ram_rdata[2*DataW-1:DataW];

  ctli_ram #(
    .Width (2 * DataW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(in_index)),
    .wdata_i ({in_ordinate, in_abscissa}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared multiply/divide unit.
  md_req_t md_req;
  md_rsp_t md_rsp;
  logic    den_ok;

  assign den_ok         = !den_q[MagW-1] && (den_q != '0);
  assign md_req.start   = (state_q == SPrep) && den_ok;
  assign md_req.ady     = dy_q[MagW-1] ? (~dy_q + 1'b1) : dy_q;
  assign md_req.adx     = dx_q[MagW-1] ? (~dx_q + 1'b1) : dx_q;
  assign md_req.den     = den_q;

  ctli_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Search compare and the final sum.
  logic             hit;
  logic [CntW-1:0]  n_clamped;
  logic [MagW+2:0]  r_sum;

  assign hit = ($signed(x_cur) > $signed(query_q));
  assign n_clamped = ({23'd0, count_q} > 32'(TableDepth)) ? CntW'(TableDepth)
                                                          : CntW'(count_q);
  assign r_sum = neg_q
    ? {{4{y_prev_q[DataW-1]}}, y_prev_q} - {2'b00, mag_q}
    : {{4{y_prev_q[DataW-1]}}, y_prev_q} + {2'b00, mag_q};

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    s_d       = s_q;
    query_d   = query_q;
    x_prev_d  = x_prev_q;
    y_prev_d  = y_prev_q;
    dy_d      = dy_q;
    dx_d      = dx_q;
    den_d     = den_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    unique case (state_q)
      SIdle: begin
        if (in_xfer) begin
          if (in_func == FuncWrite) begin
            res_val_d = '0;
            res_st_d  = StWrite;
            state_d   = SFin;
          end else if (n_clamped == '0) begin
            res_val_d = '0;
            res_st_d  = StEmpty;
            state_d   = SFin;
          end else begin
            n_d     = n_clamped;
            s_d     = '0;
            query_d = in_abscissa;
            state_d = SSrch;
          end
        end
      end
      SSrch: begin
        // The RAM output holds entry s; the read of entry s + 1 is already issued.
        if (hit) begin
          if (s_q == '0) begin
            res_val_d = half_floor(y_cur);
            res_st_d  = StBelow;
            state_d   = SFin;
          end else begin
            dy_d    = {y_cur[DataW-1], y_cur} - {y_prev_q[DataW-1], y_prev_q};
            dx_d    = {query_q[DataW-1], query_q} - {x_prev_q[DataW-1], x_prev_q};
            den_d   = {x_cur[DataW-1], x_cur} - {x_prev_q[DataW-1], x_prev_q};
            state_d = SPrep;
          end
        end else begin
          x_prev_d = x_cur;
          y_prev_d = y_cur;
          s_d      = s_q + 1'b1;
          if (s_q + 1'b1 == n_q) begin
            res_val_d = half_floor(y_cur);
            res_st_d  = StAbove;
            state_d   = SFin;
          end
        end
      end
      SPrep: begin
        neg_d = dy_q[MagW-1] ^ dx_q[MagW-1];
        if (den_ok) begin
          state_d = SArith;
        end else begin
          res_val_d = '0;
          res_st_d  = StFault;
          state_d   = SFin;
        end
      end
      SArith: begin
        if (md_rsp.done) begin
          if (|md_rsp.quot[ProdW-1:MagW+1]) begin
            mag_d = '1;
          end else begin
            mag_d = md_rsp.quot[MagW:0];
          end
          state_d = SRes;
        end
      end
      SRes: begin
        if ($signed(r_sum) > $signed({5'd0, {(DataW-1){1'b1}}})) begin
          res_val_d = {1'b0, {(DataW-1){1'b1}}};
          res_st_d  = StFault;
        end else if ($signed(r_sum) < $signed({4'hF, 1'b1, {(DataW-1){1'b0}}})) begin
          res_val_d = {1'b1, {(DataW-1){1'b0}}};
          res_st_d  = StFault;
        end else begin
          res_val_d = r_sum[DataW-1:0];
          res_st_d  = StInterp;
        end
        state_d = SFin;
      end
      SFin: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = res_val_q;
          m_user_d  = res_st_q;
          state_d   = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    s_q       <= s_d;
    query_q   <= query_d;
    x_prev_q  <= x_prev_d;
    y_prev_q  <= y_prev_d;
    dy_q      <= dy_d;
    dx_q      <= dx_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    mag_q     <= mag_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of the curve table interpolation core: directed rows, then
// random phases of table loads and lookups, checked against a predictor of its own.
// Depends on ctli_pkg and curve_table_linear_interp_core.
`timescale 1ns / 1ps

module testbench;
  import ctli_pkg::*;

  localparam int LongStall = 2000;

  typedef struct packed {
    logic        func;
    logic [7:0]  index;
    logic [31:0] x;
    logic [31:0] y;
  } curve_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } curve_result_t;

  typedef enum logic {RowCount, RowItem} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    curve_item_t   item;
    bit            typed;
    curve_result_t result;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [8:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [71:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  wire         cfg_ready;
  wire         s_tready;
  wire         m_tvalid;
  wire  [31:0] m_tdata;
  wire  [2:0]  m_tuser;

  // Predictor state: the sample table, which slots hold data, and the count in use.
  logic [31:0] x_tab [TableDepth];
  logic [31:0] y_tab [TableDepth];
  bit          loaded [TableDepth];
  logic [8:0]  count_in_use = '0;

  curve_result_t results_due[$];
  directed_row_t directed_rows[$];
  int mismatches = 0;
  int tx_idle_pct = 19;
  int rx_idle_pct = 77;
  int stall_requested = 0;
  int stall_served = 0;

  always #5 clk_i = ~clk_i;

  curve_table_linear_interp_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // Applies one item to the predictor state and returns the result it must produce.
  function automatic curve_result_t interpolate_curve(input curve_item_t it);
    curve_result_t     res;
    int unsigned       n;
    int unsigned       s;
    longint            y0, dy, dx, den, r;
    longint unsigned   ady, adx, mag;
    bit                neg;
    res.value = '0;
    if (it.func == FuncWrite) begin
      x_tab[it.index] = it.x;
      y_tab[it.index] = it.y;
      loaded[it.index] = 1'b1;
      res.status = StWrite;
      return res;
    end
    n = (count_in_use > TableDepth) ? TableDepth : count_in_use;
    if (n == 0) begin
      res.status = StEmpty;
      return res;
    end
    s = 0;
    while (s < n && $signed(x_tab[s]) <= $signed(it.x)) s++;
    if (s == 0) begin
      res.value = {y_tab[0][31], y_tab[0][31:1]};
      res.status = StBelow;
    end else if (s >= n) begin
      res.value = {y_tab[n-1][31], y_tab[n-1][31:1]};
      res.status = StAbove;
    end else begin
      y0  = $signed(y_tab[s-1]);
      dy  = $signed(y_tab[s]) - $signed(y_tab[s-1]);
      dx  = $signed(it.x) - $signed(x_tab[s-1]);
      den = $signed(x_tab[s]) - $signed(x_tab[s-1]);
      if (den <= 0) begin
        res.status = StFault;
      end else begin
        ady = (dy < 0) ? -dy : dy;
        adx = (dx < 0) ? -dx : dx;
        neg = (dy < 0) != (dx < 0);
        mag = (ady * adx) / den;
        if (mag > 64'h3_FFFF_FFFF) mag = 64'h3_FFFF_FFFF;
        r = neg ? y0 - $signed(mag) : y0 + $signed(mag);
        if (r > 64'sd2147483647) begin
          res.value = 32'h7FFF_FFFF;
          res.status = StFault;
        end else if (r < -64'sd2147483648) begin
          res.value = 32'h8000_0000;
          res.status = StFault;
        end else begin
          res.value = r[31:0];
          res.status = StInterp;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one item; the expectation is recorded at the edge where the transfer happens.
  task automatic send_item(input curve_item_t it, input bit typed = 1'b0,
                           input curve_result_t typed_res = '0);
    curve_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata  = {it.y, it.x, it.index};
    s_tuser  = it.func;
    do @(posedge clk_i); while (!s_tready);
    predicted = interpolate_curve(it);
    results_due.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  // The count is only changed once every outstanding result has come back.
  task automatic set_sample_count(input logic [8:0] count);
    drain_results();
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data  = count;
    do @(posedge clk_i); while (!cfg_ready);
    count_in_use = count;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(input row_kind_e kind, input logic func, input logic [7:0] index,
                         input logic [31:0] x, input logic [31:0] y, input bit typed = 1'b0,
                         input logic [31:0] value = '0, input logic [2:0] status = StInterp);
    directed_row_t row;
    row.kind   = kind;
    row.item   = '{func: func, index: index, x: x, y: y};
    row.typed  = typed;
    row.result = '{value: value, status: status};
    directed_rows.push_back(row);
  endtask

  // Loads entries 0..n-1 with strictly ascending x; sometimes the steps are kept narrow.
  task automatic load_ascending(input int unsigned n);
    longint      span;
    longint      x;
    curve_item_t it;
    span = 64'd4294967296 / (n + 1);
    if ($urandom_range(3) == 0 && span > (64'd1 << 20)) span = 64'd1 << $urandom_range(20, 1);
    x = $urandom_range(span - 1, 0);
    x = x - 64'sd2147483648;
    for (int unsigned k = 0; k < n; k++) begin
      it = '{func: FuncWrite, index: k[7:0], x: x[31:0], y: $urandom};
      send_item(it);
      x = x + 1 + $urandom_range(span - 1, 0);
    end
  endtask

  // Mostly queries inside an interval of the loaded table, some on a sample and some anywhere.
  function automatic logic [31:0] pick_query(input int unsigned n);
    int unsigned k;
    longint      lo, hi;
    int unsigned mode;
    mode = $urandom_range(9);
    if (n == 0 || mode < 2) return $urandom;
    k = $urandom_range(n - 1);
    if (mode == 2) return x_tab[k];
    if (mode == 3) return x_tab[0] - $urandom_range(1000, 1);
    lo = $signed(x_tab[k]);
    hi = (k + 1 < n) ? longint'($signed(x_tab[k + 1])) : lo + 65536;
    if (hi <= lo) return x_tab[k];
    lo = lo + $urandom_range(hi - lo - 1, 0);
    return lo[31:0];
  endfunction

  task automatic run_phase(input logic [8:0] count, input bit reload, input int lookups,
                           input bit long_stall = 1'b0);
    int unsigned n;
    curve_item_t it;
    set_sample_count(count);
    n = (count > TableDepth) ? TableDepth : count;
    for (int unsigned k = 0; k < n; k++) if (!loaded[k]) reload = 1'b1;
    if (reload) load_ascending(n);
    if (long_stall) stall_requested++;
    for (int i = 0; i < lookups; i++) begin
      if ($urandom_range(9) == 0) begin
        // Stray write to any slot, which may break the ordering of the table.
        it = '{func: FuncWrite, index: 8'($urandom), x: $urandom, y: $urandom};
      end else begin
        it = '{func: FuncEval, index: 8'($urandom), x: pick_query(n), y: $urandom};
      end
      send_item(it);
    end
  endtask

  // Receiver: random back-pressure, with one long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_served != stall_requested) begin
        stall_served = stall_requested;
        m_tready = 1'b0;
        repeat (LongStall - 1) @(negedge clk_i);
      end else begin
        m_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    curve_result_t due;
    if (rst_ni && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result transfer", m_tdata, '0);
      end else begin
        due = results_due.pop_front();
        if (m_tdata !== due.value) report_mismatch("curve_value", m_tdata, due.value);
        if (m_tuser !== due.status) begin
          report_mismatch("status", 32'(m_tuser), 32'(due.status));
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table, then loads at the extremes of x and y, then lookups around them.
    add_row(RowCount, FuncWrite, 8'd0, 32'd0, 32'd0);
    add_row(RowItem, FuncEval, 8'd0, 32'h0000_0000, 32'h0, 1, 32'h0, StEmpty);
    add_row(RowItem, FuncEval, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h0, StEmpty);
    add_row(RowItem, FuncWrite, 8'd0, 32'h8000_0000, 32'h8000_0001, 1, 32'h0, StWrite);
    add_row(RowItem, FuncWrite, 8'd1, 32'h0000_0000, 32'h0002_0000, 1, 32'h0, StWrite);
    add_row(RowItem, FuncWrite, 8'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h0, StWrite);
    add_row(RowItem, FuncWrite, 8'd255, 32'h0000_1234, 32'hFFFF_FFFF, 1, 32'h0, StWrite);
    add_row(RowCount, FuncWrite, 8'd0, 32'd1, 32'd0);
    add_row(RowItem, FuncEval, 8'd0, 32'h8000_0000, 32'h0, 1, 32'hC000_0000, StAbove);
    add_row(RowCount, FuncWrite, 8'd0, 32'd3, 32'd0);
    add_row(RowItem, FuncEval, 8'd0, 32'h8000_0000, 32'h0);
    add_row(RowItem, FuncEval, 8'd0, 32'h7FFF_FFFF, 32'h0, 1, 32'h3FFF_FFFF, StAbove);
    add_row(RowItem, FuncEval, 8'd0, 32'h7FFF_FFFE, 32'h0);
    add_row(RowItem, FuncEval, 8'd0, 32'hFFFF_FFFF, 32'h0);
    add_row(RowItem, FuncWrite, 8'd0, 32'hFFFF_0000, 32'h8000_0000, 1, 32'h0, StWrite);
    add_row(RowItem, FuncEval, 8'd0, 32'h8000_0000, 32'h0, 1, 32'hC000_0000, StBelow);
    add_row(RowItem, FuncEval, 8'd0, 32'hFFFF_8000, 32'h0);
    add_row(RowItem, FuncWrite, 8'd0, 32'h8000_0000, 32'h8000_0000, 1, 32'h0, StWrite);
    add_row(RowItem, FuncWrite, 8'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h0, StWrite);
    add_row(RowCount, FuncWrite, 8'd0, 32'd2, 32'd0);
    add_row(RowItem, FuncEval, 8'd0, 32'h0000_0000, 32'h0);
    add_row(RowItem, FuncEval, 8'd0, 32'h7FFF_FFFF, 32'h0, 1, 32'h3FFF_FFFF, StAbove);
    add_row(RowItem, FuncWrite, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0, StWrite);
    add_row(RowItem, FuncWrite, 8'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h0, StWrite);
    add_row(RowItem, FuncEval, 8'd0, 32'h0000_0000, 32'h0);
    add_row(RowItem, FuncEval, 8'd0, 32'h7FFF_FFFE, 32'h0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowCount) begin
        set_sample_count(directed_rows[i].item.x[8:0]);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    run_phase(9'd4, 1'b1, 40);
    run_phase(9'd1, 1'b1, 20);
    run_phase(9'd17, 1'b1, 40);

    tx_idle_pct = 77;
    rx_idle_pct = 19;
    run_phase(9'd2, 1'b1, 30);
    run_phase(9'd256, 1'b1, 30);
    // A count above the table depth behaves as a full table.
    run_phase(9'd511, 1'b0, 20);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(9'd0, 1'b0, 12);
    run_phase(9'd9, 1'b1, 40, 1'b1);
    run_phase(9'd100, 1'b1, 40);
    run_phase(9'd3, 1'b1, 40);

    drain_results();
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
